/* rtl/core/lifs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifs_pkg: shared types and constants of the lamp ignition sequencer
// Field widths, phase and register codes, and the timing helpers that the
// sequencer modules and the checker use.
// ----------------------------------------------------------------------------
package lifs_pkg;

    // Width of every duration, pause and elapsed-time counter.
    localparam int TIME_BITS  = 10;
    localparam int CFG_BITS   = 10;
    localparam int LEVEL_BITS = 7;
    localparam int PHASE_BITS = 3;
    localparam int COUNT_BITS = 3;
    localparam int TGT_BITS   = 8;
    localparam int RAND_BITS  = 16;
    localparam int CIDX_BITS  = 2;
    localparam int FACT_BITS  = 7;
    localparam int PROD_BITS  = TIME_BITS + FACT_BITS;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Phase codes.
    localparam logic [PHASE_BITS-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_WARMUP = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_ON     = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_OFF    = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_STAB   = 3'd4;

    // Request codes.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_BITS-1:0] CFG_INITIAL_PAUSE  = 2'd0;
    localparam logic [CIDX_BITS-1:0] CFG_MIN_PAUSE      = 2'd1;
    localparam logic [CIDX_BITS-1:0] CFG_STABILIZE_TIME = 2'd2;
    localparam logic [CIDX_BITS-1:0] CFG_GLOW_LEVEL     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_BITS-1:0]   RST_INITIAL_PAUSE  = 10'd400;
    localparam logic [CFG_BITS-1:0]   RST_MIN_PAUSE      = 10'd20;
    localparam logic [CFG_BITS-1:0]   RST_STABILIZE_TIME = 10'd150;
    localparam logic [LEVEL_BITS-1:0] RST_GLOW_LEVEL     = 7'd10;

    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 7'd100;

    typedef struct packed {
        logic [CFG_BITS-1:0]   initial_pause;
        logic [CFG_BITS-1:0]   min_pause;
        logic [CFG_BITS-1:0]   stabilize_time;
        logic [LEVEL_BITS-1:0] glow_level;
    } t_cfg;

    // Random values already reduced to their ranges.
    typedef struct packed {
        logic [COUNT_BITS-1:0] flicker_count;   // 3..6
        logic [6:0]            on_time;         // 20..79
        logic [9:0]            warmup_time;     // 200..599
        logic [LEVEL_BITS-1:0] flicker_level;   // 50..100
        logic [FACT_BITS-1:0]  decay_factor;    // 60..79
    } t_draws;

    typedef struct packed {
        logic                  req_type;
        logic [TGT_BITS-1:0]   target_power;
        logic [RAND_BITS-1:0]  rand_a;
        logic [RAND_BITS-1:0]  rand_b;
    } t_req;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] brightness;
        logic                  brightness_update;
        logic                  active;
        logic [PHASE_BITS-1:0] phase;
    } t_res;

    // Saturate a duration to the counter width.
    function automatic logic [TIME_BITS-1:0] sat_time(input logic [15:0] v);
        if (v > 16'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return v[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lifs_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifs_ifs: request and result channels of the lamp ignition sequencer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lifs_req_if
    import lifs_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [TGT_BITS-1:0]  target_power;
    logic [RAND_BITS-1:0] rand_a;
    logic [RAND_BITS-1:0] rand_b;

    modport source (output valid, output req_type, output target_power,
                    output rand_a, output rand_b, input ready);
    modport sink   (input valid, input req_type, input target_power,
                    input rand_a, input rand_b, output ready);
endinterface

interface lifs_res_if
    import lifs_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] brightness;
    logic                  brightness_update;
    logic                  active;
    logic [PHASE_BITS-1:0] phase;

    modport source (output valid, output brightness, output brightness_update,
                    output active, output phase, input ready);
    modport sink   (input valid, input brightness, input brightness_update,
                    input active, input phase, output ready);
endinterface

`default_nettype wire

/* rtl/core/lamp_ignition_flicker_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lamp_ignition_flicker_sequencer: gas-lamp ignition sequencer
// Start beats restart the ignition; millisecond tick beats walk it through
// warmup, flicker on/off, stabilize and idle. One result beat per request.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Beat contents                                   Port
//  --------  ----  ----------------------------------------------  --------
//  request   in    req_type, target_power, rand_a, rand_b          i_req
//  result    out   brightness, brightness_update, active, phase    o_res
//  config    in    register index and data, write enable only      i_cfg_*
//
//  A request beat is captured in an input register, processed by the phase
//  machine as it moves into the result register and held there until taken;
//  one beat is accepted every cycle while the result side keeps taking beats.
//  The result register and the input register stall together when the
//  result side holds off ready; nothing is dropped or repeated.
//  Reset is synchronous and active low; it idles the phase machine, empties
//  both registers and loads the configuration defaults.
//
// ----------------------------------------------------------------------------
module lamp_ignition_flicker_sequencer
    import lifs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    lifs_req_if.sink                  i_req,
    lifs_res_if.source                o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CIDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]  i_cfg_data
);

    // Input stage.
    logic   r_in_valid;
    t_req   r_in;

    // Result stage.
    logic   r_out_valid;
    t_res   r_out;

    t_cfg   s_cfg;
    t_draws s_draws;
    t_res   s_res;
    logic   s_advance;
    logic   s_go;
    logic   s_in_ready;

    // The result register can take a new beat when it is empty or draining.
    assign s_advance  = !r_out_valid || o_res.ready;
    assign s_go       = r_in_valid && s_advance;
    assign s_in_ready = !r_in_valid || s_advance;
    assign i_req.ready = s_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (s_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && s_in_ready) begin
            r_in.req_type     <= i_req.req_type;
            r_in.target_power <= i_req.target_power;
            r_in.rand_a       <= i_req.rand_a;
            r_in.rand_b       <= i_req.rand_b;
        end
        if (s_go) begin
            r_out <= s_res;
        end
    end

    lifs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (s_cfg)
    );

    lifs_draw u_draw (
        .i_rand_a (r_in.rand_a),
        .i_rand_b (r_in.rand_b),
        .o_draws  (s_draws)
    );

    // The phase machine advances only on the cycle a beat moves from the input
    // register into the result register; the decayed pause is stored on its own.
    lifs_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (s_go),
        .i_req_type     (r_in.req_type),
        .i_target_power (r_in.target_power),
        .i_draws        (s_draws),
        .i_cfg          (s_cfg),
        .o_res          (s_res)
    );

    assign o_res.valid             = r_out_valid;
    assign o_res.brightness        = r_out.brightness;
    assign o_res.brightness_update = r_out.brightness_update;
    assign o_res.active            = r_out.active;
    assign o_res.phase             = r_out.phase;

endmodule

`default_nettype wire

/* rtl/core/lifs_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifs_cfg: configuration registers
// Four write-only registers loaded from a simple write port.
// ----------------------------------------------------------------------------
module lifs_cfg
    import lifs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CIDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INITIAL_PAUSE:  n_cfg.initial_pause  = i_cfg_data;
                CFG_MIN_PAUSE:      n_cfg.min_pause      = i_cfg_data;
                CFG_STABILIZE_TIME: n_cfg.stabilize_time = i_cfg_data;
                CFG_GLOW_LEVEL:     n_cfg.glow_level     = i_cfg_data[LEVEL_BITS-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_pause  <= RST_INITIAL_PAUSE;
            r_cfg.min_pause      <= RST_MIN_PAUSE;
            r_cfg.stabilize_time <= RST_STABILIZE_TIME;
            r_cfg.glow_level     <= RST_GLOW_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/core/lifs_draw.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifs_draw: range reduction of the random words
// Each draw is lo + (word mod (hi - lo)); the moduli are split into a power
// of two and an odd factor reduced by digit folding or reciprocal multiply.
// ----------------------------------------------------------------------------
module lifs_draw
    import lifs_pkg::*;
(
    input  wire logic [RAND_BITS-1:0] i_rand_a,
    input  wire logic [RAND_BITS-1:0] i_rand_b,
    output t_draws                    o_draws
);

    // rand_a[15:2] mod 15 and mod 5: 16 is 1 modulo both, so nibbles add up.
    logic [5:0]  s_nib;
    logic [4:0]  s_fold;
    logic [3:0]  s_m15;
    logic [2:0]  s_m5;

    // rand_b[15:4] mod 25 through a reciprocal multiply (exact for 12 bits).
    logic [11:0] s_hi12;
    logic [22:0] s_recip;
    logic [7:0]  s_q25;
    logic [11:0] s_r25;

    // rand_b mod 51: 256 is 1 modulo 51, so bytes add up.
    logic [8:0]  s_byte;
    logic [8:0]  s_byte2;
    logic [7:0]  s_b8;
    logic [5:0]  s_m51;

    always_comb begin
        s_nib  = 6'(i_rand_a[5:2]) + 6'(i_rand_a[9:6]) + 6'(i_rand_a[13:10])
               + 6'(i_rand_a[15:14]);
        s_fold = 5'(s_nib[5:4]) + 5'(s_nib[3:0]);
        s_m15  = (s_fold >= 5'd15) ? 4'(s_fold - 5'd15) : s_fold[3:0];
        priority if (s_m15 >= 4'd10) begin
            s_m5 = 3'(s_m15 - 4'd10);
        end else if (s_m15 >= 4'd5) begin
            s_m5 = 3'(s_m15 - 4'd5);
        end else begin
            s_m5 = s_m15[2:0];
        end

        s_hi12  = i_rand_b[15:4];
        s_recip = 23'(s_hi12) * 23'd1311;
        s_q25   = s_recip[22:15];
        s_r25   = s_hi12 - (12'(s_q25) * 12'd25);

        s_byte  = 9'(i_rand_b[15:8]) + 9'(i_rand_b[7:0]);
        s_byte2 = 9'(s_byte[8]) + 9'(s_byte[7:0]);
        s_b8    = s_byte2[7:0];
        priority if (s_b8 >= 8'd255) begin
            s_m51 = 6'(s_b8 - 8'd255);
        end else if (s_b8 >= 8'd204) begin
            s_m51 = 6'(s_b8 - 8'd204);
        end else if (s_b8 >= 8'd153) begin
            s_m51 = 6'(s_b8 - 8'd153);
        end else if (s_b8 >= 8'd102) begin
            s_m51 = 6'(s_b8 - 8'd102);
        end else if (s_b8 >= 8'd51) begin
            s_m51 = 6'(s_b8 - 8'd51);
        end else begin
            s_m51 = s_b8[5:0];
        end

        o_draws.flicker_count = 3'(i_rand_a[1:0]) + 3'd3;
        o_draws.on_time       = 7'd20 + 7'({s_m15, i_rand_a[1:0]});
        o_draws.decay_factor  = 7'd60 + 7'({s_m5, i_rand_a[1:0]});
        o_draws.warmup_time   = 10'd200 + 10'({s_r25[4:0], i_rand_b[3:0]});
        o_draws.flicker_level = 7'd50 + 7'(s_m51);
    end

endmodule

`default_nettype wire

/* rtl/core/lifs_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifs_step: ignition phase machine
// Holds the sequence state and forms one result for each item it is given.
// The decayed pause is divided by 100 in the cycle after the flicker-off
// step, which is always before the next flicker-off step needs it.
// ----------------------------------------------------------------------------
module lifs_step
    import lifs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_go,
    input  wire logic                i_req_type,
    input  wire logic [TGT_BITS-1:0] i_target_power,
    input  t_draws                   i_draws,
    input  t_cfg                     i_cfg,
    output t_res                     o_res
);

    logic [PHASE_BITS-1:0] r_phase,   n_phase;
    logic [LEVEL_BITS-1:0] r_target,  n_target;
    logic [COUNT_BITS-1:0] r_flicks,  n_flicks;
    logic [TIME_BITS-1:0]  r_pause,   n_pause;
    logic [TIME_BITS-1:0]  r_step,    n_step;
    logic [TIME_BITS-1:0]  r_elapsed, n_elapsed;
    logic [PROD_BITS-1:0]  r_prod,    n_prod;
    logic                  r_pend,    n_pend;

    logic [PHASE_BITS-1:0] s_ph;
    logic [TIME_BITS-1:0]  s_el_inc;
    logic [PROD_BITS-3:0]  s_quarter;
    logic [PROD_BITS+10:0] s_div_mul;
    logic [TIME_BITS-1:0]  s_div100;
    logic [TIME_BITS-1:0]  s_floor;
    logic [TIME_BITS-1:0]  s_settled;
    logic [COUNT_BITS-1:0] s_fl_dec;
    logic [8:0]            s_tgt4;
    logic [16:0]           s_stab_mul;
    logic [LEVEL_BITS-1:0] s_stab_lvl;
    logic [LEVEL_BITS-1:0] s_glow;

    function automatic logic [PHASE_BITS-1:0] ph_norm(input logic [PHASE_BITS-1:0] p);
        if (p >= PH_WARMUP && p <= PH_STAB) begin
            return p;
        end
        return PH_IDLE;
    endfunction

    always_comb begin
        s_ph     = ph_norm(r_phase);
        s_el_inc = (r_elapsed < TIME_MAX) ? r_elapsed + 1'b1 : r_elapsed;

        // prod / 100 = (prod / 4) / 25, the latter by reciprocal 5243 / 2^17.
        s_quarter = r_prod[PROD_BITS-1:2];
        s_div_mul = (PROD_BITS+11)'(s_quarter) * (PROD_BITS+11)'(5243);
        s_div100  = s_div_mul[17 +: TIME_BITS];
        s_floor   = sat_time(16'(i_cfg.min_pause));
        s_settled = (s_div100 < s_floor) ? s_floor : s_div100;

        s_fl_dec = (r_flicks != '0) ? r_flicks - 1'b1 : r_flicks;

        // target * 4 / 5 through reciprocal 205 / 2^10, exact for these values.
        s_tgt4     = {r_target, 2'b00};
        s_stab_mul = 17'(s_tgt4) * 17'd205;
        s_stab_lvl = s_stab_mul[16:10];

        s_glow = (i_cfg.glow_level > LEVEL_FULL) ? LEVEL_FULL : i_cfg.glow_level;

        n_phase   = r_phase;
        n_target  = r_target;
        n_flicks  = r_flicks;
        n_step    = r_step;
        n_elapsed = r_elapsed;
        n_prod    = r_prod;
        n_pend    = 1'b0;
        n_pause   = r_pend ? s_settled : r_pause;

        o_res = '0;

        if (i_go) begin
            if (i_req_type == REQ_START) begin
                n_target  = (i_target_power > 8'(LEVEL_FULL)) ? LEVEL_FULL
                                                               : i_target_power[6:0];
                n_flicks  = i_draws.flicker_count;
                n_pause   = sat_time(16'(i_cfg.initial_pause));
                n_phase   = PH_WARMUP;
                n_step    = sat_time(16'(i_draws.warmup_time));
                n_elapsed = '0;
                o_res.brightness        = s_glow;
                o_res.brightness_update = 1'b1;
                o_res.active            = 1'b1;
            end else if (s_ph != PH_IDLE) begin
                o_res.active = 1'b1;
                n_elapsed    = s_el_inc;
                if (s_el_inc >= r_step) begin
                    n_elapsed = '0;
                    o_res.brightness_update = 1'b1;
                    unique case (s_ph)
                        PH_WARMUP: begin
                            n_phase = PH_ON;
                            n_step  = sat_time(16'(i_draws.on_time));
                            o_res.brightness = i_draws.flicker_level;
                        end
                        PH_ON: begin
                            n_phase = PH_OFF;
                            n_step  = r_pause;
                            n_prod  = PROD_BITS'(r_pause) * PROD_BITS'(i_draws.decay_factor);
                            n_pend  = 1'b1;
                            o_res.brightness = '0;
                        end
                        PH_OFF: begin
                            n_flicks = s_fl_dec;
                            if (s_fl_dec != '0) begin
                                n_phase = PH_ON;
                                n_step  = sat_time(16'(i_draws.on_time));
                                o_res.brightness = i_draws.flicker_level;
                            end else begin
                                n_phase = PH_STAB;
                                n_step  = sat_time(16'(i_cfg.stabilize_time));
                                o_res.brightness = s_stab_lvl;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            o_res.brightness = r_target;
                        end
                    endcase
                end
            end
            o_res.phase = ph_norm(n_phase);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_target  <= '0;
            r_flicks  <= '0;
            r_pause   <= '0;
            r_step    <= '0;
            r_elapsed <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_target  <= n_target;
            r_flicks  <= n_flicks;
            r_pause   <= n_pause;
            r_step    <= n_step;
            r_elapsed <= n_elapsed;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

endmodule

`default_nettype wire

/* rtl/core/lifs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifs_checker: port-level checks of the ignition sequencer
// Relations between the result fields and the state after reset.
// ----------------------------------------------------------------------------
module lifs_checker
    import lifs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_res_valid,
    input wire logic [LEVEL_BITS-1:0] i_brightness,
    input wire logic                  i_update,
    input wire logic                  i_active,
    input wire logic [PHASE_BITS-1:0] i_phase
);

    // A result without an update carries a zero level.
    a_quiet_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_update |-> i_brightness == '0)
        else $error("brightness nonzero without update");

    // A tick on an idle lamp changes nothing and stays idle.
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_active |-> !i_update && i_phase == PH_IDLE)
        else $error("inactive result shows update or phase");

    // Entering flicker on shows a flame level between 50 and 100.
    a_flicker_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_update && i_phase == PH_ON
        |-> i_brightness >= 7'd50 && i_brightness <= LEVEL_FULL)
        else $error("flicker-on level out of range");

    // Entering flicker off darkens the lamp.
    a_flicker_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_update && i_phase == PH_OFF |-> i_brightness == '0)
        else $error("flicker-off level not zero");

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind lamp_ignition_flicker_sequencer lifs_checker u_lifs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_brightness (o_res.brightness),
    .i_update     (o_res.brightness_update),
    .i_active     (o_res.active),
    .i_phase      (o_res.phase)
);

`default_nettype wire

/* bench/lamp_ignition_flicker_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_ignition_flicker_sequencer_tb: self-checking bench of the ignition
// sequencer
// Request beats come from a queue that the stimulus process fills. A local
// copy of the lamp phase machine works out the expected result beat for each
// accepted request, and the result monitor compares beats field by field.
// The run walks one whole ignition, including warmup, flicker, stabilize and
// idle, then restarts the lamp under random register settings, with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module lamp_ignition_flicker_sequencer_tb;
    import lifs_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 4;
    localparam int MAX_WAIT     = 19;
    localparam int QUIET_LIMIT  = 2000;  // cycles without any beat
    localparam int SETTLE       = 8;     // quiet cycles after the pipe drains
    localparam int ITEM_GOAL    = 400;   // fewest request beats in the whole run
    localparam int MIN_ROUNDS   = 6;     // fewest restarts under random settings
    localparam int REPORT_LIMIT = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we;
    logic [CIDX_BITS-1:0] cfg_idx;
    logic [CFG_BITS-1:0]  cfg_data;

    lifs_req_if lamp_req ();
    lifs_res_if lamp_res ();

    lamp_ignition_flicker_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (lamp_req),
        .o_res      (lamp_res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Local copy of the lamp: register settings and phase machine state.
    // ------------------------------------------------------------------------
    logic [CFG_BITS-1:0]   set_init_pause;
    logic [CFG_BITS-1:0]   set_min_pause;
    logic [CFG_BITS-1:0]   set_stab_time;
    logic [LEVEL_BITS-1:0] set_glow;

    logic [PHASE_BITS-1:0] lamp_phase;
    logic [LEVEL_BITS-1:0] lamp_target;
    logic [COUNT_BITS-1:0] flicks_left;
    logic [TIME_BITS-1:0]  pause_now;
    logic [TIME_BITS-1:0]  step_len;
    logic [TIME_BITS-1:0]  elapsed;

    t_req lamp_pending[$];   // request beats not yet offered
    t_res lamp_expected[$];  // predicted result beats, oldest first

    int  n_queued  = 0;
    int  n_taken   = 0;
    int  n_results = 0;
    int  n_errors  = 0;
    int  quiet     = 0;
    bit  req_fired = 1'b0;
    bit  res_fired = 1'b0;

    // Per-side pacing: runs of beats either back to back or with random gaps.
    int  send_gap   = 0;
    int  send_run   = 0;
    bit  send_eager = 1'b0;
    int  recv_stall = 0;
    int  recv_run   = 0;
    bit  recv_eager = 1'b0;

    // A random word reduced into [lo, hi): lo included, hi excluded.
    function automatic int unsigned reduce_word(logic [RAND_BITS-1:0] w,
                                                int unsigned lo, int unsigned hi);
        return lo + (w % (hi - lo));
    endfunction

    function automatic logic [TIME_BITS-1:0] clamp_ms(int unsigned v);
        return (v > TIME_MAX) ? TIME_MAX : v[TIME_BITS-1:0];
    endfunction

    function automatic logic lamp_running(logic [PHASE_BITS-1:0] p);
        return (p >= PH_WARMUP) && (p <= PH_STAB);
    endfunction

    // One request through the phase machine; returns the beat it must produce.
    function automatic t_res ignite_step(t_req r);
        t_res        o;
        int unsigned decayed;
        o = '0;
        if (r.req_type == REQ_START) begin
            // A start restarts from any phase and lights the glow level.
            lamp_target = (r.target_power > LEVEL_FULL) ? LEVEL_FULL
                                                        : r.target_power[LEVEL_BITS-1:0];
            flicks_left = COUNT_BITS'(reduce_word(r.rand_a, 3, 7));
            pause_now   = clamp_ms(set_init_pause);
            lamp_phase  = PH_WARMUP;
            step_len    = clamp_ms(reduce_word(r.rand_b, 200, 600));
            elapsed     = '0;
            o.brightness        = (set_glow > LEVEL_FULL) ? LEVEL_FULL : set_glow;
            o.brightness_update = 1'b1;
            o.active            = 1'b1;
        end else if (lamp_running(lamp_phase)) begin
            o.active = 1'b1;
            // The millisecond count saturates at the top of the time width.
            if (elapsed < TIME_MAX) begin
                elapsed++;
            end
            if (elapsed >= step_len) begin
                elapsed             = '0;
                o.brightness_update = 1'b1;
                case (lamp_phase)
                    PH_WARMUP: begin
                        lamp_phase   = PH_ON;
                        step_len     = clamp_ms(reduce_word(r.rand_a, 20, 80));
                        o.brightness = LEVEL_BITS'(reduce_word(r.rand_b, 50, 101));
                    end
                    PH_ON: begin
                        // The dark gap uses the current pause, then the pause
                        // shrinks for the next one but never below the floor.
                        lamp_phase   = PH_OFF;
                        step_len     = pause_now;
                        o.brightness = '0;
                        decayed      = (pause_now * reduce_word(r.rand_a, 60, 80)) / 100;
                        pause_now    = (decayed < set_min_pause) ? clamp_ms(set_min_pause)
                                                                 : clamp_ms(decayed);
                    end
                    PH_OFF: begin
                        if (flicks_left != '0) begin
                            flicks_left--;
                        end
                        if (flicks_left != '0) begin
                            lamp_phase   = PH_ON;
                            step_len     = clamp_ms(reduce_word(r.rand_a, 20, 80));
                            o.brightness = LEVEL_BITS'(reduce_word(r.rand_b, 50, 101));
                        end else begin
                            lamp_phase   = PH_STAB;
                            step_len     = clamp_ms(set_stab_time);
                            o.brightness = LEVEL_BITS'((lamp_target * 4) / 5);
                        end
                    end
                    default: begin
                        lamp_phase   = PH_IDLE;
                        o.brightness = lamp_target;
                    end
                endcase
            end
        end
        o.phase = lamp_running(lamp_phase) ? lamp_phase : PH_IDLE;
        return o;
    endfunction

    function automatic int next_wait(inout int run_left, inout bit eager);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 80);
            eager    = ($urandom_range(0, 1) == 0);
        end
        run_left--;
        return eager ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic note_failure(string msg);
        n_errors++;
        if (n_errors <= REPORT_LIMIT) begin
            $display("MISMATCH %s", msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: offers queued beats at the falling edge, holding each
    // until it is taken, with a drawn gap in front of every beat.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_req nxt;
        if (i_rst_n) begin
            if (lamp_req.valid && !req_fired) begin
                // Beat still offered: keep it as it is.
            end else if (lamp_pending.size() != 0) begin
                if (send_gap > 0) begin
                    lamp_req.valid <= 1'b0;
                    send_gap--;
                end else begin
                    nxt = lamp_pending.pop_front();
                    lamp_req.valid        <= 1'b1;
                    lamp_req.req_type     <= nxt.req_type;
                    lamp_req.target_power <= nxt.target_power;
                    lamp_req.rand_a       <= nxt.rand_a;
                    lamp_req.rand_b       <= nxt.rand_b;
                    send_gap = next_wait(send_run, send_eager);
                end
            end else begin
                lamp_req.valid <= 1'b0;
            end
        end
    end

    // Result side: after each beat, hold ready low for a drawn number of cycles.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_fired) begin
                recv_stall = next_wait(recv_run, recv_eager);
            end
            if (recv_stall > 0) begin
                lamp_res.ready <= 1'b0;
                recv_stall--;
            end else begin
                lamp_res.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge, predicts for a taken request beat and
    // checks a taken result beat against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_req seen;
        t_res got;
        t_res want;
        if (i_rst_n) begin
            req_fired = lamp_req.valid && lamp_req.ready;
            res_fired = lamp_res.valid && lamp_res.ready;
            if (req_fired) begin
                seen.req_type     = lamp_req.req_type;
                seen.target_power = lamp_req.target_power;
                seen.rand_a       = lamp_req.rand_a;
                seen.rand_b       = lamp_req.rand_b;
                lamp_expected.push_back(ignite_step(seen));
                n_taken++;
            end
            if (res_fired) begin
                got.brightness        = lamp_res.brightness;
                got.brightness_update = lamp_res.brightness_update;
                got.active            = lamp_res.active;
                got.phase             = lamp_res.phase;
                n_results++;
                if (lamp_expected.size() == 0) begin
                    note_failure($sformatf("beat %0d arrived with nothing expected: %p",
                                           n_results, got));
                end else begin
                    want = lamp_expected.pop_front();
                    if (got.brightness !== want.brightness) begin
                        note_failure($sformatf("beat %0d brightness: expected %0d, got %0d",
                                               n_results, want.brightness, got.brightness));
                    end
                    if (got.brightness_update !== want.brightness_update) begin
                        note_failure($sformatf("beat %0d update: expected %0d, got %0d",
                                               n_results, want.brightness_update,
                                               got.brightness_update));
                    end
                    if (got.active !== want.active) begin
                        note_failure($sformatf("beat %0d active: expected %0d, got %0d",
                                               n_results, want.active, got.active));
                    end
                    if (got.phase !== want.phase) begin
                        note_failure($sformatf("beat %0d phase: expected %0d, got %0d",
                                               n_results, want.phase, got.phase));
                    end
                end
            end
            // Watchdog: a stuck handshake on either channel ends the run.
            if (req_fired || res_fired) begin
                quiet = 0;
            end else if (++quiet >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_item(logic req, logic [TGT_BITS-1:0] tgt,
                              logic [RAND_BITS-1:0] a, logic [RAND_BITS-1:0] b);
        t_req item;
        item.req_type     = req;
        item.target_power = tgt;
        item.rand_a       = a;
        item.rand_b       = b;
        lamp_pending.push_back(item);
        n_queued++;
    endtask

    // A word that gives a warmup near its shortest, which keeps a whole
    // ignition affordable; upper bits still vary.
    function automatic logic [RAND_BITS-1:0] short_warmup_word();
        return RAND_BITS'($urandom_range(0, 163) * 400 + $urandom_range(0, 24));
    endfunction

    // Tick words mostly give a flicker-on time in its lower third; the decay
    // factor still spans its whole range.
    function automatic logic [RAND_BITS-1:0] tick_word();
        if ($urandom_range(0, 7) == 0) begin
            return RAND_BITS'($urandom);
        end
        return RAND_BITS'($urandom_range(0, 1091) * 60 + $urandom_range(0, 19));
    endfunction

    task automatic queue_start(bit short_warmup);
        queue_item(REQ_START, TGT_BITS'($urandom_range(0, 255)),
                   RAND_BITS'($urandom),
                   short_warmup ? short_warmup_word() : RAND_BITS'($urandom));
    endtask

    task automatic queue_tick();
        queue_item(REQ_TICK, TGT_BITS'($urandom_range(0, 255)),
                   tick_word(), RAND_BITS'($urandom));
    endtask

    // Holds the stimulus off until every queued beat has come back.
    task automatic wait_drained();
        while (lamp_pending.size() != 0 || n_results < n_queued) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_register(logic [CIDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx)
            CFG_INITIAL_PAUSE:  set_init_pause = data;
            CFG_MIN_PAUSE:      set_min_pause  = data;
            CFG_STABILIZE_TIME: set_stab_time  = data;
            CFG_GLOW_LEVEL:     set_glow       = data[LEVEL_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Settings change only with nothing in flight.
    task automatic load_settings(logic [CFG_BITS-1:0] init_pause,
                                 logic [CFG_BITS-1:0] min_pause,
                                 logic [CFG_BITS-1:0] stab_time,
                                 logic [CFG_BITS-1:0] glow);
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        set_register(CFG_INITIAL_PAUSE, init_pause);
        set_register(CFG_MIN_PAUSE, min_pause);
        set_register(CFG_STABILIZE_TIME, stab_time);
        set_register(CFG_GLOW_LEVEL, glow);
    endtask

    // Whole ignitions: a start, then ticks until the lamp is back at idle.
    // Now and then the sender drains the pipe.
    task automatic run_ignitions(int count);
        for (int s = 0; s < count; s++) begin
            queue_start(1'b1);
            while (n_taken < n_queued) begin
                @(negedge i_clk);
            end
            while (lamp_running(lamp_phase)) begin
                @(negedge i_clk);
                if (lamp_pending.size() < 4) begin
                    if ($urandom_range(0, 255) == 0) begin
                        wait_drained();
                    end else begin
                        repeat ($urandom_range(1, 8)) queue_tick();
                    end
                end
            end
            // A few ticks at idle, which must leave the lamp alone.
            repeat ($urandom_range(0, 3)) queue_tick();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        cfg_we                = 1'b0;
        cfg_idx               = CFG_INITIAL_PAUSE;
        cfg_data              = '0;
        lamp_req.valid        = 1'b0;
        lamp_req.req_type     = REQ_START;
        lamp_req.target_power = '0;
        lamp_req.rand_a       = '0;
        lamp_req.rand_b       = '0;
        lamp_res.ready        = 1'b0;

        // Reset values of the registers and of the phase machine.
        set_init_pause = RST_INITIAL_PAUSE;
        set_min_pause  = RST_MIN_PAUSE;
        set_stab_time  = RST_STABILIZE_TIME;
        set_glow       = RST_GLOW_LEVEL;
        lamp_phase     = PH_IDLE;
        lamp_target    = '0;
        flicks_left    = '0;
        pause_now      = '0;
        step_len       = '0;
        elapsed        = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part under the reset settings. Ticks at idle report an
        // inactive lamp; targets above 100 are clamped; the random words hit
        // both ends of the flicker-count and warmup ranges.
        queue_item(REQ_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
        queue_item(REQ_TICK, 8'h00, 16'h0000, 16'h0000);
        queue_item(REQ_START, 8'hFF, 16'h0000, 16'h0000);
        queue_item(REQ_TICK, 8'h00, 16'hFFFF, 16'hFFFF);
        queue_item(REQ_START, 8'd101, 16'd3, 16'd399);
        queue_item(REQ_TICK, 8'hAA, 16'h5555, 16'hAAAA);
        queue_item(REQ_START, 8'd100, 16'hFFFF, 16'hFFFF);
        queue_item(REQ_START, 8'd0, 16'd1, 16'd1);
        queue_item(REQ_START, 8'd99, 16'h8000, 16'h8000);
        repeat (4) queue_tick();
        wait_drained();

        // One whole ignition under short settings. The decayed pause falls
        // below the floor, which then holds it, and a glow level above 100
        // is clamped.
        load_settings(10'd4, 10'd2, 10'd1, 10'd101);
        run_ignitions(1);

        // Restarts under random settings, each followed by up to six warmup ticks.
        // The glow word may have bits above the register width set.
        for (int r = 0; r < MIN_ROUNDS || n_queued < ITEM_GOAL; r++) begin
            load_settings(CFG_BITS'($urandom_range(1, 1023)),
                          CFG_BITS'($urandom_range(0, 1023)),
                          CFG_BITS'($urandom_range(1, 1023)),
                          CFG_BITS'({$urandom_range(0, 7), 7'($urandom_range(0, 127))}));
            queue_start(1'b0);
            repeat ($urandom_range(0, 6)) queue_tick();
        end

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        if (n_errors == 0 && lamp_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lifs_pkg.sv
rtl/core/lifs_ifs.sv
rtl/core/lifs_cfg.sv
rtl/core/lifs_draw.sv
rtl/core/lifs_step.sv
rtl/core/lamp_ignition_flicker_sequencer.sv
rtl/core/lifs_checker.sv
bench/lamp_ignition_flicker_sequencer_tb.sv
